>>> design/dtq_pkg.sv
// shared types, constants and ordering function for the deadline timer queue
`default_nettype none
package dtq_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned MaxResults  = 64;
  localparam int unsigned ResCntW     = $clog2(MaxResults + 1);
  localparam int unsigned ResAddrW    = $clog2(MaxResults);
  localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] period;
    logic [7:0]  id;
  } entry_t;

  // order by time remaining, then by id
  function automatic logic before_f(entry_t a, entry_t b, logic [31:0] now);
    logic [31:0] ra;
    logic [31:0] rb;
    ra = a.deadline - now;
    rb = b.deadline - now;
    if (ra != rb) return ra < rb;
    return a.id < b.id;
  endfunction

endpackage
`default_nettype wire

>>> design/deadline_timer_queue_top.sv
// deadline timer queue: top level
// A command is taken on a clock edge with start_i high and busy_o low:
// opcode 0 adds a timer (deadline now+delay, delay zero counts as one, period
// zero means one-shot), 1 deletes the first stored entry with the id, 2 is a
// one millisecond tick that fires up to MaxResults expired timers in deadline
// order (ties to the smaller id) and reloads periodic ones. Opcode 3 is ignored.
// Results come out one per cycle marked by valid_o, last_o on the final one;
// every result of a command carries the same time_to_next_ms_o (all ones when
// the queue is empty). Fired ids are buffered and sent after the tick's heap
// work, so a tick gives one result per fired timer or one report with ok 0.
// The receiver cannot stall; results are not held.
// Timers live in a binary heap in one memory with a registered read; each heap
// level of a sift up reads the parent, then compares; a level of a sift down
// reads the left child, then the right, then compares. A delete first scans
// the stored entries for the id in index order.
// Reset empties the queue and sets time to zero; no clearing pass is needed.
`default_nettype none
module deadline_timer_queue_top #(
  parameter int unsigned CAPACITY = dtq_pkg::DefCapacity
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  timer_id_i,
  input  wire logic [31:0] delay_ms_i,
  input  wire logic [31:0] period_ms_i,
  output logic             valid_o,
  output logic [1:0]       kind_o,
  output logic             ok_o,
  output logic [7:0]       fired_id_o,
  output logic [31:0]      time_to_next_ms_o,
  output logic             last_o
);
  import dtq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                hw_we;
  logic [AW-1:0]       hw_addr, hr_addr;
  entry_t              hw_data, hr_data;
  logic                fw_we;
  logic [ResAddrW-1:0] fw_addr, fr_addr;
  logic [7:0]          fw_data, fr_data;

  // heap memory
  dtq_heap_ram #(.CAPACITY(CAPACITY), .AW(AW)) u_heap (
    .clk_i, .we_i(hw_we), .waddr_i(hw_addr), .wdata_i(hw_data),
    .raddr_i(hr_addr), .rdata_o(hr_data)
  );

  // fired id buffer
  dtq_fire_buf u_fire (
    .clk_i, .we_i(fw_we), .waddr_i(fw_addr), .wdata_i(fw_data),
    .raddr_i(fr_addr), .rdata_o(fr_data)
  );

  // sequencer
  dtq_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .timer_id_i, .delay_ms_i,
    .period_ms_i, .valid_o, .kind_o, .ok_o, .fired_id_o, .time_to_next_ms_o,
    .last_o,
    .hw_we_o(hw_we), .hw_addr_o(hw_addr), .hw_data_o(hw_data),
    .hr_addr_o(hr_addr), .hr_data_i(hr_data),
    .fw_we_o(fw_we), .fw_addr_o(fw_addr), .fw_data_o(fw_data),
    .fr_addr_o(fr_addr), .fr_data_i(fr_data)
  );
endmodule
`default_nettype wire

>>> design/dtq_heap_ram.sv
// heap storage: one write port, one registered read port
`default_nettype none
module dtq_heap_ram #(
  parameter int unsigned CAPACITY = dtq_pkg::DefCapacity,
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire dtq_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output dtq_pkg::entry_t      rdata_o
);
  import dtq_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

>>> design/dtq_fire_buf.sv
// buffer of fired timer ids held until the tick report goes out
`default_nettype none
module dtq_fire_buf (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [dtq_pkg::ResAddrW-1:0]  waddr_i,
  input  wire logic [7:0]                    wdata_i,
  input  wire logic [dtq_pkg::ResAddrW-1:0]  raddr_i,
  output logic [7:0]                         rdata_o
);
  import dtq_pkg::*;

  logic [7:0] mem [MaxResults];
  logic [7:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

>>> design/dtq_ctrl.sv
// sequencer: add, delete search, tick firing, heap sifts and result output
`default_nettype none
module dtq_ctrl #(
  parameter int unsigned CAPACITY = dtq_pkg::DefCapacity,
  parameter int unsigned AW       = $clog2(CAPACITY),
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [7:0]                    timer_id_i,
  input  wire logic [31:0]                   delay_ms_i,
  input  wire logic [31:0]                   period_ms_i,
  output logic                               valid_o,
  output logic [1:0]                         kind_o,
  output logic                               ok_o,
  output logic [7:0]                         fired_id_o,
  output logic [31:0]                        time_to_next_ms_o,
  output logic                               last_o,
  output logic                               hw_we_o,
  output logic [AW-1:0]                      hw_addr_o,
  output dtq_pkg::entry_t                    hw_data_o,
  output logic [AW-1:0]                      hr_addr_o,
  input  wire dtq_pkg::entry_t               hr_data_i,
  output logic                               fw_we_o,
  output logic [dtq_pkg::ResAddrW-1:0]       fw_addr_o,
  output logic [7:0]                         fw_data_o,
  output logic [dtq_pkg::ResAddrW-1:0]       fr_addr_o,
  input  wire logic [7:0]                    fr_data_i
);
  import dtq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DEL_RD, S_DEL_CMP, S_RM_START, S_RM_LAST, S_SD_RDL, S_SD_RDR,
    S_SD_CMP, S_SU_RD, S_SU_CMP, S_AFTER, S_TK_RD, S_TK_CHK, S_FIN_RD,
    S_FIN_CAP, S_EM_PRE, S_EM_OUT
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic [31:0]         now_q, now_d;
  entry_t              e_q, e_d;
  entry_t              lc_q, lc_d;
  entry_t              root_q, root_d;
  logic [AW-1:0]       i_q, i_d;
  logic [ResCntW-1:0]  n_q, n_d;
  logic [ResCntW-1:0]  k_q, k_d;
  logic                first_q, first_d;
  logic                pend_q, pend_d;
  logic                adv_q, adv_d;
  logic                has_r_q, has_r_d;
  logic [7:0]          id_q, id_d;
  logic [31:0]         delay_q, delay_d;
  logic [31:0]         period_q, period_d;
  logic                ok_q, ok_d;
  logic [31:0]         next_q, next_d;
  logic                valid_q, valid_d;
  logic [1:0]          kind_q, kind_d;
  logic                rok_q, rok_d;
  logic [7:0]          rid_q, rid_d;
  logic                last_q, last_d;

  logic [AW+1:0]       l_w, r_w, cnt_w;
  logic [AW-1:0]       parent_w;
  logic [CW-1:0]       cm1_w;
  logic [31:0]         now_inc_w;
  logic [31:0]         dly_w;

  assign l_w       = {1'b0, i_q, 1'b1};
  assign r_w       = l_w + 1'b1;
  assign cnt_w     = (AW+2)'(count_q);
  assign parent_w  = (i_q - 1'b1) >> 1;
  assign cm1_w     = count_q - 1'b1;
  assign now_inc_w = now_q + 32'd1;
  assign dly_w     = (delay_q == 32'd0) ? 32'd1 : delay_q;

  // next-state and memory port logic
  always_comb begin
    state_d = state_q; op_d = op_q; count_d = count_q; scan_d = scan_q;
    now_d = now_q; e_d = e_q; lc_d = lc_q; root_d = root_q; i_d = i_q;
    n_d = n_q; k_d = k_q; first_d = first_q; pend_d = pend_q; adv_d = adv_q;
    has_r_d = has_r_q; id_d = id_q; delay_d = delay_q; period_d = period_q;
    ok_d = ok_q; next_d = next_q;
    valid_d = 1'b0; kind_d = kind_q; rok_d = rok_q; rid_d = rid_q; last_d = last_q;
    hw_we_o = 1'b0; hw_addr_o = i_q; hw_data_o = e_q; hr_addr_o = '0;
    fw_we_o = 1'b0; fw_addr_o = n_q[ResAddrW-1:0]; fw_data_o = root_q.id;
    fr_addr_o = k_q[ResAddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          id_d = timer_id_i; delay_d = delay_ms_i; period_d = period_ms_i;
          ok_d = 1'b0; n_d = '0; scan_d = '0; pend_d = 1'b0; adv_d = 1'b1;
          unique case (opcode_i)
            OP_ADD:  begin op_d = OP_ADD;  state_d = S_AFTER; pend_d = 1'b1; end
            OP_DEL:  begin op_d = OP_DEL;  state_d = S_DEL_RD; end
            OP_TICK: begin op_d = OP_TICK; state_d = S_TK_RD; end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // linear id search: read an entry, then compare its id
      S_DEL_RD: begin
        hr_addr_o = scan_q[AW-1:0];
        if (scan_q == count_q) state_d = S_FIN_RD;
        else                   state_d = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        if (hr_data_i.id == id_q) begin
          ok_d = 1'b1; i_d = scan_q[AW-1:0]; state_d = S_RM_START;
        end else begin
          scan_d = scan_q + 1'b1; state_d = S_DEL_RD;
        end
      end
      // remove slot i: move the last entry into it
      S_RM_START: begin
        count_d   = cm1_w;
        hr_addr_o = cm1_w[AW-1:0];
        if ((AW+1)'(i_q) == (AW+1)'(cm1_w)) state_d = S_AFTER;
        else                                state_d = S_RM_LAST;
      end
      S_RM_LAST: begin
        e_d = hr_data_i; first_d = 1'b1; state_d = S_SD_RDL;
      end
      // sift down
      S_SD_RDL: begin
        hr_addr_o = l_w[AW-1:0];
        if (l_w >= cnt_w) begin
          if (first_q) state_d = S_SU_RD;
          else begin hw_we_o = 1'b1; state_d = S_AFTER; end
        end else state_d = S_SD_RDR;
      end
      S_SD_RDR: begin
        lc_d      = hr_data_i;
        hr_addr_o = r_w[AW-1:0];
        has_r_d   = r_w < cnt_w;
        state_d   = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (has_r_q && before_f(hr_data_i, lc_q, now_q) &&
            before_f(hr_data_i, e_q, now_q)) begin
          hw_we_o = 1'b1; hw_data_o = hr_data_i;
          i_d = r_w[AW-1:0]; first_d = 1'b0; state_d = S_SD_RDL;
        end else if (before_f(lc_q, e_q, now_q)) begin
          hw_we_o = 1'b1; hw_data_o = lc_q;
          i_d = l_w[AW-1:0]; first_d = 1'b0; state_d = S_SD_RDL;
        end else if (first_q) begin
          state_d = S_SU_RD;
        end else begin
          hw_we_o = 1'b1; state_d = S_AFTER;
        end
      end
      // sift up
      S_SU_RD: begin
        hr_addr_o = parent_w;
        if (i_q == '0) begin hw_we_o = 1'b1; state_d = S_AFTER; end
        else state_d = S_SU_CMP;
      end
      S_SU_CMP: begin
        hw_we_o = 1'b1;
        if (before_f(e_q, hr_data_i, now_q)) begin
          hw_data_o = hr_data_i; i_d = parent_w; state_d = S_SU_RD;
        end else state_d = S_AFTER;
      end
      // pending insert, then back to the operation
      S_AFTER: begin
        if (pend_q) begin
          pend_d = 1'b0; first_d = 1'b0;
          if (op_q == OP_ADD) begin
            if (count_q < CW'(CAPACITY)) begin
              ok_d = 1'b1;
              e_d = '{deadline: now_q + dly_w, period: period_q, id: id_q};
              i_d = count_q[AW-1:0]; count_d = count_q + 1'b1; state_d = S_SU_RD;
            end else state_d = S_FIN_RD;
          end else begin
            e_d = '{deadline: now_q + root_q.period, period: root_q.period,
                    id: root_q.id};
            i_d = count_q[AW-1:0]; count_d = count_q + 1'b1; state_d = S_SU_RD;
          end
        end else if (op_q == OP_TICK) state_d = S_TK_RD;
        else state_d = S_FIN_RD;
      end
      // tick: check root, fire while expired
      S_TK_RD: begin
        hr_addr_o = '0;
        if (count_q == '0) begin
          if (adv_q) now_d = now_inc_w;
          adv_d = 1'b0; state_d = S_FIN_RD;
        end else if (n_q == ResCntW'(MaxResults)) state_d = S_FIN_RD;
        else state_d = S_TK_CHK;
      end
      S_TK_CHK: begin
        root_d = hr_data_i;
        adv_d  = 1'b0;
        if (adv_q && hr_data_i.deadline != now_q) begin
          now_d = now_inc_w;
          if (hr_data_i.deadline == now_inc_w) begin
            fw_we_o = 1'b1; fw_data_o = hr_data_i.id; n_d = n_q + 1'b1;
            pend_d = hr_data_i.period != 32'd0; i_d = '0; state_d = S_RM_START;
          end else state_d = S_FIN_RD;
        end else if (hr_data_i.deadline == now_q) begin
          fw_we_o = 1'b1; fw_data_o = hr_data_i.id; n_d = n_q + 1'b1;
          pend_d = hr_data_i.period != 32'd0; i_d = '0; state_d = S_RM_START;
        end else state_d = S_FIN_RD;
      end
      // time to next deadline
      S_FIN_RD: begin
        hr_addr_o = '0;
        if (count_q == '0) begin next_d = AllOnes; state_d = S_EM_PRE; end
        else state_d = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        next_d = hr_data_i.deadline - now_q; state_d = S_EM_PRE;
      end
      // result output
      S_EM_PRE: begin
        fr_addr_o = '0; k_d = '0;
        if (op_q == OP_TICK && n_q != '0) state_d = S_EM_OUT;
        else begin
          valid_d = 1'b1; kind_d = op_q; rok_d = ok_q; rid_d = '0; last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EM_OUT: begin
        fr_addr_o = ResAddrW'(k_q + 1'b1);
        valid_d = 1'b1; kind_d = OP_TICK; rok_d = 1'b1; rid_d = fr_data_i;
        k_d = k_q + 1'b1;
        last_d = (k_q + 1'b1) == n_q;
        if ((k_q + 1'b1) == n_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; now_q <= '0; valid_q <= 1'b0;
      op_q <= OP_ADD; n_q <= '0; k_q <= '0; pend_q <= 1'b0; adv_q <= 1'b0;
      first_q <= 1'b0; has_r_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; now_q <= now_d; valid_q <= valid_d;
      op_q <= op_d; n_q <= n_d; k_q <= k_d; pend_q <= pend_d; adv_q <= adv_d;
      first_q <= first_d; has_r_q <= has_r_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d; e_q <= e_d; lc_q <= lc_d; root_q <= root_d; i_q <= i_d;
    id_q <= id_d; delay_q <= delay_d; period_q <= period_d; ok_q <= ok_d;
    next_q <= next_d; kind_q <= kind_d; rok_q <= rok_d; rid_q <= rid_d;
    last_q <= last_d;
  end

  assign busy_o            = state_q != S_IDLE;
  assign valid_o           = valid_q;
  assign kind_o            = kind_q;
  assign ok_o              = rok_q;
  assign fired_id_o        = rid_q;
  assign time_to_next_ms_o = next_q;
  assign last_o            = last_q;
endmodule
`default_nettype wire

>>> dv/deadline_timer_queue_top_test.sv
// self-checking testbench for the deadline timer queue
`timescale 1ns / 100ps
`default_nettype none
module deadline_timer_queue_top_test;
  import dtq_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [7:0]  fired_id;
    logic [31:0] ttn;
    logic        last;
  } timer_res_t;

  // predicts timer queue results and holds them until the block sends them
  class timer_scoreboard;
    logic [31:0] dl[Cap];
    logic [31:0] per[Cap];
    logic [7:0]  ids[Cap];
    int unsigned count;
    logic [31:0] now;
    timer_res_t  pending[$];
    int unsigned errors;

    function void clear();
      count = 0;
      now = 0;
      errors = 0;
      pending.delete();
    endfunction

    function logic earlier(int unsigned a, int unsigned b);
      logic [31:0] ra;
      logic [31:0] rb;
      ra = dl[a] - now;
      rb = dl[b] - now;
      if (ra != rb) return ra < rb;
      return ids[a] < ids[b];
    endfunction

    function void swap_at(int unsigned a, int unsigned b);
      logic [31:0] d;
      logic [31:0] p;
      logic [7:0]  t;
      d = dl[a]; p = per[a]; t = ids[a];
      dl[a] = dl[b]; per[a] = per[b]; ids[a] = ids[b];
      dl[b] = d; per[b] = p; ids[b] = t;
    endfunction

    function void raise(int unsigned i);
      int unsigned up;
      while (i > 0) begin
        up = (i - 1) / 2;
        if (!earlier(i, up)) break;
        swap_at(i, up);
        i = up;
      end
    endfunction

    function void lower(int unsigned i);
      int unsigned l;
      int unsigned best;
      forever begin
        l = 2 * i + 1;
        best = i;
        if (l < count && earlier(l, best)) best = l;
        if (l + 1 < count && earlier(l + 1, best)) best = l + 1;
        if (best == i) break;
        swap_at(i, best);
        i = best;
      end
    endfunction

    function void push(logic [31:0] d, logic [31:0] p, logic [7:0] t);
      dl[count] = d; per[count] = p; ids[count] = t;
      count++;
      raise(count - 1);
    endfunction

    function void drop(int unsigned i);
      count--;
      if (i != count) begin
        dl[i] = dl[count]; per[i] = per[count]; ids[i] = ids[count];
        lower(i);
        raise(i);
      end
    endfunction

    // note one accepted command and queue its results
    function void note_command(op_e op, logic [7:0] tid, logic [31:0] dly,
                               logic [31:0] prd);
      timer_res_t r[$];
      timer_res_t e;
      logic [31:0] ttn;
      logic [7:0]  fid;
      logic [31:0] fp;
      logic        hit;
      hit = 0;
      e = '0;
      if (op == OP_ADD) begin
        if (count < Cap) begin
          push(now + ((dly == 0) ? 32'd1 : dly), prd, tid);
          hit = 1;
        end
        e.kind = OP_ADD; e.ok = hit; e.last = 1; r = {r, e};
      end else if (op == OP_DEL) begin
        for (int unsigned i = 0; i < count; i++) begin
          if (ids[i] == tid) begin
            drop(i);
            hit = 1;
            break;
          end
        end
        e.kind = OP_DEL; e.ok = hit; e.last = 1; r = {r, e};
      end else if (op == OP_TICK) begin
        if (count == 0 || dl[0] != now) now++;
        while (r.size() < MaxResults && count > 0 && dl[0] == now) begin
          fid = ids[0]; fp = per[0];
          drop(0);
          if (fp != 0) push(now + fp, fp, fid);
          e.kind = OP_TICK; e.ok = 1; e.fired_id = fid; e.last = 0;
          r = {r, e};
        end
        if (r.size() == 0) begin
          e.kind = OP_TICK; r = {r, e};
        end
        r[r.size() - 1].last = 1;
      end else begin
        return;
      end
      ttn = (count == 0) ? AllOnes : dl[0] - now;
      foreach (r[k]) begin
        r[k].ttn = ttn;
        pending = {pending, r[k]};
      end
    endfunction

    // compare one result with the oldest expectation
    function void check_result(timer_res_t got);
      timer_res_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d id=%0d", $time, got.kind, got.fired_id);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.kind != w.kind)
        $display("%0t: kind expected %0d actual %0d", $time, w.kind, got.kind);
      if (got.ok != w.ok)
        $display("%0t: ok expected %0d actual %0d", $time, w.ok, got.ok);
      if (got.fired_id != w.fired_id)
        $display("%0t: fired_id expected %0d actual %0d", $time, w.fired_id, got.fired_id);
      if (got.ttn != w.ttn)
        $display("%0t: time_to_next expected %0h actual %0h", $time, w.ttn, got.ttn);
      if (got.last != w.last)
        $display("%0t: last expected %0d actual %0d", $time, w.last, got.last);
      if (got != w) errors++;
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic [1:0]  opcode_i = '0;
  logic [7:0]  timer_id_i = '0;
  logic [31:0] delay_ms_i = '0;
  logic [31:0] period_ms_i = '0;
  logic        busy_o, valid_o, ok_o, last_o;
  logic [1:0]  kind_o;
  logic [7:0]  fired_id_o;
  logic [31:0] time_to_next_ms_o;

  timer_scoreboard sb;
  int unsigned quiet_cycles = 0;
  bit          calm = 0;

  deadline_timer_queue_top uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .timer_id_i, .delay_ms_i,
    .period_ms_i, .valid_o, .kind_o, .ok_o, .fired_id_o, .time_to_next_ms_o, .last_o
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_result({kind_o, ok_o, fired_id_o, time_to_next_ms_o, last_o});
      if (valid_o || (start_i && !busy_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one command transfer, with an optional gap before it
  task automatic send(op_e op, logic [7:0] tid, logic [31:0] dly, logic [31:0] prd);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 19)) @(negedge clk_i);
    opcode_i <= op;
    timer_id_i <= tid;
    delay_ms_i <= dly;
    period_ms_i <= prd;
    start_i <= 1;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(op, tid, dly, prd);
    @(negedge clk_i);
    start_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom();
      2: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin
    int n;
    sb = new();
    sb.clear();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: empty queue, extremes, zero delay, ties, duplicates
    send(OP_TICK, 8'd0, 0, 0);
    send(OP_DEL, 8'd5, 0, 0);
    send(OP_ADD, 8'd255, 32'd0, 32'd0);
    send(OP_ADD, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_ADD, 8'd9, 32'd2, 32'd3);
    send(OP_ADD, 8'd4, 32'd2, 32'd0);
    send(OP_ADD, 8'd4, 32'd5, 32'd1);
    send(OP_TICK, 8'd0, 0, 0);
    send(OP_TICK, 8'd0, 0, 0);
    send(OP_DEL, 8'd4, 0, 0);
    send(OP_DEL, 8'd200, 0, 0);
    send(op_e'(2'd3), 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send(OP_TICK, 8'd0, 0, 0);
    send(OP_DEL, 8'd0, 0, 0);
    drain();
    // fill to capacity with a shared deadline, then overflow and fire those timers
    for (int i = 0; i < Cap + 1; i++) send(OP_ADD, 8'(i ^ 8'h5A), 32'd1, 32'd0);
    send(OP_TICK, 8'd0, 0, 0);
    drain();

    // random part, timer traffic mostly over a small id set, with some ignored opcode 3 commands
    n = 0;
    while (n < 130) begin
      int sel;
      if (n > 100) calm = 1;
      if (n == 60) drain();
      sel = $urandom_range(0, 9);
      if (sel < 4)
        send(OP_ADD, ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 15)),
             pick_delay(), ($urandom_range(0, 1) == 0) ? 32'd0 :
             (($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(1, 9))));
      else if (sel < 6)
        send(OP_DEL, ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 15)),
             $urandom(), $urandom());
      else if (sel < 9)
        send(OP_TICK, 8'($urandom()), $urandom(), $urandom());
      else
        send(op_e'(($urandom_range(0, 5) == 0) ? 2'd3 : 2'd2), 8'($urandom()), 0, 0);
      n++;
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
